### rtl/sm3_hash_engine_defines.svh
// Assertion helpers for the SM3 hash engine; expect clk and rst in scope.
`ifndef SM3_HASH_ENGINE_DEFINES_SVH
`define SM3_HASH_ENGINE_DEFINES_SVH

`define SM3_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define SM3_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/sm3_pkg.sv
`default_nettype none
package sm3_pkg;

  typedef logic [31:0] word_t;
  typedef logic [7:0][31:0] state_t;
  typedef logic [63:0][7:0] blk_t;

  localparam logic [2:0] BUF_HOLD  = 3'd0;
  localparam logic [2:0] BUF_DATA  = 3'd1;
  localparam logic [2:0] BUF_PAD   = 3'd2;
  localparam logic [2:0] BUF_LEN   = 3'd3;
  localparam logic [2:0] BUF_SHIFT = 3'd4;

  typedef struct packed {
    logic [2:0]  op;
    logic [5:0]  pos;
    logic [2:0]  cnt;
    logic [31:0] data;
    logic [63:0] bitlen;
  } buf_ctl_t;

  localparam word_t T_LOW  = 32'h79CC4519;
  localparam word_t T_HIGH = 32'h7A879D8A;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam int LEN_POS = 56;

  localparam state_t IV = {32'hB0FB0E4E, 32'hE38DEE4D, 32'h163138AA, 32'hA96F30BC,
                           32'hDA8A0600, 32'h172442D7, 32'h4914B2B9, 32'h7380166F};

  function automatic word_t rotl32(word_t x, logic [4:0] n);
    logic [5:0] back;
    back = 6'd32 - {1'b0, n};
    return (x << n) | (x >> back);
  endfunction

  function automatic word_t p0(word_t x);
    return x ^ rotl32(x, 5'd9) ^ rotl32(x, 5'd17);
  endfunction

  function automatic word_t p1(word_t x);
    return x ^ rotl32(x, 5'd15) ^ rotl32(x, 5'd23);
  endfunction

  function automatic word_t t_rot(logic [5:0] j);
    return rotl32((j < 6'd16) ? T_LOW : T_HIGH, j[4:0]);
  endfunction

  function automatic word_t blk_word(blk_t b, logic [3:0] i);
    return {b[{i, 2'd0}], b[{i, 2'd1}], b[{i, 2'd2}], b[{i, 2'd3}]};
  endfunction

endpackage
`default_nettype wire

### rtl/sm3_round.sv
`default_nettype none
module sm3_round (
  input  wire sm3_pkg::state_t st,
  input  wire sm3_pkg::word_t  wj,
  input  wire sm3_pkg::word_t  wj4,
  input  wire logic [5:0]      rnd,
  output sm3_pkg::state_t      nxt
);

  sm3_pkg::word_t a12, ss1, ss2, ff, gg, tt1, tt2;

  always_comb begin
    a12 = sm3_pkg::rotl32(st[0], 5'd12);
    ss1 = sm3_pkg::rotl32(a12 + st[4] + sm3_pkg::t_rot(rnd), 5'd7);
    ss2 = ss1 ^ a12;
    if (rnd < 6'd16) begin
      ff = st[0] ^ st[1] ^ st[2];
      gg = st[4] ^ st[5] ^ st[6];
    end else begin
      ff = (st[0] & st[1]) | (st[0] & st[2]) | (st[1] & st[2]);
      gg = (st[4] & st[5]) | (~st[4] & st[6]);
    end
    tt1 = ff + st[3] + ss2 + (wj ^ wj4);
    tt2 = gg + st[7] + ss1 + wj;
    nxt[0] = tt1;
    nxt[1] = st[0];
    nxt[2] = sm3_pkg::rotl32(st[1], 5'd9);
    nxt[3] = st[2];
    nxt[4] = sm3_pkg::p0(tt2);
    nxt[5] = st[4];
    nxt[6] = sm3_pkg::rotl32(st[5], 5'd19);
    nxt[7] = st[6];
  end

endmodule
`default_nettype wire

### rtl/sm3_msgbuf.sv
`default_nettype none
module sm3_msgbuf (
  input  wire logic              clk,
  input  wire sm3_pkg::buf_ctl_t ctl,
  output sm3_pkg::word_t         w0,
  output sm3_pkg::word_t         w4
);

  sm3_pkg::blk_t blk, blk_next;
  sm3_pkg::word_t w_new;

  always_comb begin
    w_new = sm3_pkg::p1(sm3_pkg::blk_word(blk, 4'd0) ^ sm3_pkg::blk_word(blk, 4'd7)
                        ^ sm3_pkg::rotl32(sm3_pkg::blk_word(blk, 4'd13), 5'd15))
            ^ sm3_pkg::rotl32(sm3_pkg::blk_word(blk, 4'd3), 5'd7)
            ^ sm3_pkg::blk_word(blk, 4'd10);
  end

  assign w0 = sm3_pkg::blk_word(blk, 4'd0);
  assign w4 = sm3_pkg::blk_word(blk, 4'd4);

  always_comb begin
    logic [6:0] off;
    logic [4:0] sh;
    blk_next = blk;
    off = '0;
    sh = '0;
    unique case (ctl.op)
      sm3_pkg::BUF_HOLD: begin
        blk_next = blk;
      end
      sm3_pkg::BUF_DATA: begin
        for (int k = 0; k < 64; k++) begin
          off = 7'(k) - {1'b0, ctl.pos};
          sh = 5'd24 - {off[1:0], 3'b000};
          if (7'(k) >= {1'b0, ctl.pos} && off < {4'b0, ctl.cnt}) begin
            blk_next[k] = 8'(ctl.data >> sh);
          end
        end
      end
      sm3_pkg::BUF_PAD: begin
        for (int k = 0; k < 64; k++) begin
          if (7'(k) == {1'b0, ctl.pos}) begin
            blk_next[k] = sm3_pkg::PAD_BYTE;
          end else if (7'(k) > {1'b0, ctl.pos}) begin
            blk_next[k] = 8'h00;
          end
        end
        if (ctl.pos < 6'(sm3_pkg::LEN_POS)) begin
          for (int m = 0; m < 8; m++) begin
            blk_next[sm3_pkg::LEN_POS + m] = ctl.bitlen[63 - 8 * m -: 8];
          end
        end
      end
      sm3_pkg::BUF_LEN: begin
        blk_next = '0;
        for (int m = 0; m < 8; m++) begin
          blk_next[sm3_pkg::LEN_POS + m] = ctl.bitlen[63 - 8 * m -: 8];
        end
      end
      sm3_pkg::BUF_SHIFT: begin
        for (int k = 0; k < 60; k++) begin
          blk_next[k] = blk[k + 4];
        end
        blk_next[60] = w_new[31:24];
        blk_next[61] = w_new[23:16];
        blk_next[62] = w_new[15:8];
        blk_next[63] = w_new[7:0];
      end
      default: begin
        blk_next = blk;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    blk <= blk_next;
  end

endmodule
`default_nettype wire

### rtl/sm3_hash_engine.sv
// SM3 hash engine, one round unit reused for all 64 rounds of a block.
// A word is taken only when idle; each full 64-byte block then runs the
// rounds and a step that stores bytes left over before the next word.
// The last word adds a pad step and rounds (a length step and rounds more
// for an extra length block), then eight digest words stream out.
// Synchronous reset loads the IV and clears the byte and block counters.
`default_nettype none
`include "sm3_hash_engine_defines.svh"
module sm3_hash_engine (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // data_word
  input  wire logic [2:0]  s_tuser,   // byte_count
  input  wire logic        s_tlast,   // last
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // digest_word
  output logic [2:0]       m_tuser,   // word_index
  output logic             m_tlast    // last_word
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MORE  = 3'd1;
  localparam logic [2:0] S_ROUND = 3'd2;
  localparam logic [2:0] S_PAD   = 3'd3;
  localparam logic [2:0] S_LEN   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  localparam logic [1:0] PH_DATA  = 2'd0;
  localparam logic [1:0] PH_PAD2  = 2'd1;
  localparam logic [1:0] PH_FINAL = 2'd2;

  logic [2:0]  state;
  logic [1:0]  phase;
  logic [5:0]  pos;
  logic [54:0] block_count;
  logic        len_sat;
  logic [5:0]  round;
  logic [2:0]  out_idx;
  logic [31:0] pend_data;
  logic [2:0]  pend_cnt;
  logic        pend_last;
  sm3_pkg::state_t work, chain, rnd_out;
  sm3_pkg::buf_ctl_t ctl;
  sm3_pkg::word_t w0, w4;

  logic [2:0] cnt_lim, take;
  logic [6:0] room, pos_sum;
  logic       in_acc, out_acc;

  assign in_acc  = s_tvalid && s_tready;
  assign out_acc = m_tvalid && m_tready;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);
  assign m_tdata  = chain[0];
  assign m_tuser  = out_idx;
  assign m_tlast  = (out_idx == 3'd7);

  always_comb begin
    cnt_lim = (s_tuser > 3'd4) ? 3'd4 : s_tuser;
    room    = 7'd64 - {1'b0, pos};
    take    = ({4'b0, cnt_lim} < room) ? cnt_lim : room[2:0];
    pos_sum = {1'b0, pos} + {4'b0, take};
  end

  always_comb begin
    ctl.op     = sm3_pkg::BUF_HOLD;
    ctl.pos    = pos;
    ctl.cnt    = take;
    ctl.data   = s_tdata;
    ctl.bitlen = len_sat ? '1 : {block_count, pos, 3'b000};
    unique case (state)
      S_IDLE:  ctl.op = in_acc ? sm3_pkg::BUF_DATA : sm3_pkg::BUF_HOLD;
      S_MORE: begin
        ctl.op   = sm3_pkg::BUF_DATA;
        ctl.cnt  = pend_cnt;
        ctl.data = pend_data;
      end
      S_ROUND: ctl.op = sm3_pkg::BUF_SHIFT;
      S_PAD:   ctl.op = sm3_pkg::BUF_PAD;
      S_LEN:   ctl.op = sm3_pkg::BUF_LEN;
      default: ctl.op = sm3_pkg::BUF_HOLD;
    endcase
  end

  sm3_msgbuf u_msgbuf (
    .clk (clk),
    .ctl (ctl),
    .w0  (w0),
    .w4  (w4)
  );

  sm3_round u_round (
    .st  (work),
    .wj  (w0),
    .wj4 (w4),
    .rnd (round),
    .nxt (rnd_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      phase       <= PH_DATA;
      pos         <= '0;
      block_count <= '0;
      len_sat     <= 1'b0;
      round       <= '0;
      out_idx     <= '0;
      chain       <= sm3_pkg::IV;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            pend_data <= s_tdata << {take, 3'b000};
            pend_cnt  <= cnt_lim - take;
            pend_last <= s_tlast;
            if (pos_sum == 7'd64) begin
              pos   <= '0;
              work  <= chain;
              round <= '0;
              phase <= PH_DATA;
              state <= S_ROUND;
              if (block_count == '1) begin
                len_sat <= 1'b1;
              end else begin
                block_count <= block_count + 55'd1;
              end
            end else begin
              pos   <= pos_sum[5:0];
              state <= s_tlast ? S_PAD : S_IDLE;
            end
          end
        end
        S_MORE: begin
          pos   <= {3'b000, pend_cnt};
          state <= pend_last ? S_PAD : S_IDLE;
        end
        S_PAD: begin
          work  <= chain;
          round <= '0;
          phase <= (pos >= 6'(sm3_pkg::LEN_POS)) ? PH_PAD2 : PH_FINAL;
          state <= S_ROUND;
        end
        S_LEN: begin
          work  <= chain;
          round <= '0;
          phase <= PH_FINAL;
          state <= S_ROUND;
        end
        S_ROUND: begin
          work  <= rnd_out;
          round <= round + 6'd1;
          if (round == 6'd63) begin
            chain <= chain ^ rnd_out;
            unique case (phase)
              PH_DATA:  state <= S_MORE;
              PH_PAD2:  state <= S_LEN;
              default:  state <= S_OUT;
            endcase
          end
        end
        S_OUT: begin
          if (out_acc) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == 3'd7) begin
              chain       <= sm3_pkg::IV;
              pos         <= '0;
              block_count <= '0;
              len_sat     <= 1'b0;
              state       <= S_IDLE;
            end else begin
              chain <= {chain[0], chain[7:1]};
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `SM3_CHECK(a_sides_excl, s_tready, !m_tvalid, "input and output sides open together")
  `SM3_CHECK(a_round_rest, state != S_ROUND, round == 6'd0, "round counter off zero outside rounds")
  `SM3_CHECK_NEXT(a_msg_done, out_acc && m_tlast, s_tready && pos == 6'd0 && block_count == '0, "state not cleared after digest")

endmodule
`default_nettype wire
